// ===== rtl/wwd_pkg.sv =====
// ----------------------------------------------------------------------------
// wwd_pkg
// types and constants shared by the weighted window difficulty block
// ----------------------------------------------------------------------------
package wwd_pkg;

  typedef struct packed {
    logic [62:0] timestamp;
    logic [62:0] cumulative_difficulty;
    logic        last_record;
  } in_item_t;

  typedef struct packed {
    logic [63:0] next_difficulty;
    logic        bad_span;
  } out_item_t;

  typedef enum logic [1:0] {
    REG_TARGET_SPACING = 2'd0,
    REG_WINDOW_SIZE    = 2'd1,
    REG_FUTURE_LIMIT   = 2'd2
  } cfg_reg_e;

  localparam logic [15:0] TargetReset = 16'd120;
  localparam logic [8:0]  WindowReset = 9'd61;
  localparam logic [15:0] FutureReset = 16'd360;
  localparam logic [7:0]  FastMult    = 8'd110;
  localparam logic [7:0]  FastDiv     = 8'd100;
  localparam logic [7:0]  SlowMult    = 8'd99;
  localparam logic [7:0]  SlowDivMult = 8'd200;

  // request to the divide sequencer
  typedef struct packed {
    logic         go;
    logic [127:0] num;
    logic [63:0]  den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

endpackage

// ===== rtl/wwd_mul.sv =====
// ----------------------------------------------------------------------------
// wwd_mul
// sequential 128 x 32 multiplier, one 32 x 32 partial product per cycle
// ----------------------------------------------------------------------------
module wwd_mul (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         go_i,
  input  logic [127:0] a_i,
  input  logic [31:0]  b_i,
  output logic         done_o,
  output logic [127:0] p_o
);

  logic [127:0] a_q, a_d;
  logic [127:0] acc_q, acc_d;
  logic [31:0]  b_q, b_d;
  logic [1:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d;
  logic         done_q, done_d;
  logic [63:0]  pp;

  // one partial product on the current low word
  assign pp = {32'd0, a_q[31:0]} * {32'd0, b_q};

  always_comb begin
    a_d    = a_q;
    acc_d  = acc_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (go_i) begin
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = acc_q + ({64'd0, pp} << {cnt_q, 5'd0});
      a_d   = a_q >> 32;
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == 2'd3) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

// ===== rtl/wwd_div.sv =====
// ----------------------------------------------------------------------------
// wwd_div
// restoring divider, 128 by 64 bits, one quotient bit per cycle, saturating
// ----------------------------------------------------------------------------
module wwd_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wwd_pkg::div_req_t req_i,
  output wwd_pkg::div_rsp_t rsp_o
);

  logic [63:0] rem_q, rem_d;
  logic [63:0] lo_q, lo_d;
  logic [63:0] den_q, den_d;
  logic [63:0] quo_q, quo_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic        top;
  logic [63:0] sh;

  assign top = rem_q[63];
  assign sh  = {rem_q[62:0], lo_q[63]};

  always_comb begin
    rem_d  = rem_q;
    lo_d   = lo_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.go) begin
      den_d = req_i.den;
      lo_d  = req_i.num[63:0];
      rem_d = req_i.num[127:64];
      quo_d = '0;
      cnt_d = '0;
      // quotient overflow saturates at once
      if (req_i.num[127:64] >= req_i.den) begin
        quo_d  = '1;
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      lo_d = lo_q << 1;
      if (top || sh >= den_q) begin
        rem_d = sh - den_q;
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = sh;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// ===== rtl/weighted_window_difficulty.sv =====
// ----------------------------------------------------------------------------
// weighted_window_difficulty
// linearly weighted window difficulty retarget over a stream of records
// ----------------------------------------------------------------------------
// usage:
//   records enter oldest first on start/item_i and are taken at a clock edge
//   with start high and busy low. an ordinary record is absorbed in the
//   accumulate state, then the block returns to idle, so a new record is taken
//   only once the last one is absorbed. the record marked last_record ends the
//   set. a short set goes from accumulate straight to the result, a non
//   positive weighted sum through the wait state. otherwise a shared 128x32
//   sequential multiplier runs one priming pass, then one factor (fast rule)
//   or three factors (slow rule), and a restoring divider loads the operands
//   and then makes one quotient bit per cycle, 64 bits in all (a saturated
//   quotient is ready at once). the result is shown for one cycle with valid_o
//   high, and busy drops in the cycle after. configuration is written through
//   cfg_valid_i and cfg_ready_o with index and data, and is accepted only while
//   busy is low. reset restores the register defaults and clears all set
//   state. the receiver cannot stall: each result is shown for exactly one
//   cycle.
// ----------------------------------------------------------------------------
module weighted_window_difficulty #(
  parameter int unsigned MAX_WINDOW = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  wwd_pkg::in_item_t  item_i,
  output logic               valid_o,
  output wwd_pkg::out_item_t result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int unsigned IW = $clog2(MAX_WINDOW + 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ACC  = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_OUT  = 6'b010000,
    ST_WAIT = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [15:0] target_q;
  logic [8:0]  window_q;
  logic [15:0] future_q;

  logic [IW-1:0] idx_q, idx_d;
  logic [62:0]   prior_q, prior_d;
  logic [63:0]   wsum_q, wsum_d;
  logic [63:0]   rsum_q, rsum_d;
  logic [62:0]   first_q, first_d;
  logic [62:0]   second_q, second_d;
  logic [62:0]   newest_q, newest_d;
  wwd_pkg::in_item_t rec_q;

  logic [1:0]   step_q, step_d;
  logic         fast_q, fast_d;
  logic [63:0]  res_q, res_d;
  logic         bad_q, bad_d;

  logic         mul_go;
  logic [127:0] mul_a;
  logic [31:0]  mul_b;
  logic         mul_done;
  logic [127:0] mul_p;
  wwd_pkg::div_req_t div_req;
  wwd_pkg::div_rsp_t div_rsp;

  // clamped window and N
  logic [IW-1:0] n_w;
  always_comb begin
    if (window_q < 9'd2) n_w = IW'(1);
    else if ({23'd0, window_q} > MAX_WINDOW) n_w = IW'(MAX_WINDOW - 1);
    else n_w = IW'(window_q - 9'd1);
  end

  // configuration writes, taken only while idle; the user must keep them between sets, which the block does not enforce
  assign cfg_ready_o = (state_q == ST_IDLE);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= wwd_pkg::TargetReset;
      window_q <= wwd_pkg::WindowReset;
      future_q <= wwd_pkg::FutureReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        wwd_pkg::REG_TARGET_SPACING: target_q <= cfg_data_i;
        wwd_pkg::REG_WINDOW_SIZE:    window_q <= cfg_data_i[8:0];
        wwd_pkg::REG_FUTURE_LIMIT:   future_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped solve time of the registered record
  logic [63:0] st;
  logic [63:0] up, down, cap;
  assign up   = {1'b0, rec_q.timestamp} - {1'b0, prior_q};
  assign down = {1'b0, prior_q} - {1'b0, rec_q.timestamp};
  assign cap  = 64'({16'd0, target_q} * 32'd6);
  always_comb begin
    if (rec_q.timestamp >= prior_q) st = (up > cap) ? cap : up;
    else st = -((down > {48'd0, future_q}) ? {48'd0, future_q} : down);
  end

  logic [63:0] st_w;
  assign st_w = 64'($signed(st) * $signed({1'b0, idx_q}));

  // fast rule: S3 < floor(8T/10) holds exactly when 10*(S3+1) <= 8T
  logic [63:0] rs_inc, rs_x10, t_x8;
  assign rs_inc = rsum_q + 64'd1;
  assign rs_x10 = (rs_inc << 3) + (rs_inc << 1);
  assign t_x8   = {45'd0, target_q, 3'd0};

  logic [63:0] span;
  assign span = fast_q ? ({1'b0, newest_q} - {1'b0, second_q})
                       : ({1'b0, newest_q} - {1'b0, first_q});

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    prior_d  = prior_q;
    wsum_d   = wsum_q;
    rsum_d   = rsum_q;
    first_d  = first_q;
    second_d = second_q;
    newest_d = newest_q;
    step_d   = step_q;
    fast_d   = fast_q;
    res_d    = res_q;
    bad_d    = bad_q;
    mul_go   = 1'b0;
    mul_a    = mul_p;
    mul_b    = 32'd0;
    div_req.go  = 1'b0;
    div_req.num = mul_p;
    // 200 * L as shifts: 128 + 64 + 8
    div_req.den = (wsum_q << 7) + (wsum_q << 6) + (wsum_q << 3);
    unique case (state_q)
      ST_IDLE: if (start) state_d = ST_ACC;
      ST_ACC: begin
        // absorb one record
        if (idx_q <= n_w) begin
          if (idx_q == '0) first_d = rec_q.cumulative_difficulty;
          else begin
            wsum_d = wsum_q + st_w;
            if ({1'b0, idx_q} + 2'd3 > {1'b0, n_w}) rsum_d = rsum_q + st;
          end
          if (idx_q + IW'(1) == n_w) second_d = rec_q.cumulative_difficulty;
          if (idx_q == n_w) newest_d = rec_q.cumulative_difficulty;
          prior_d = rec_q.timestamp;
          idx_d   = idx_q + IW'(1);
        end
        if (!rec_q.last_record) state_d = ST_IDLE;
        else begin
          res_d = 64'd1;
          bad_d = 1'b0;
          step_d = '0;
          state_d = ST_OUT;
          if (((idx_q <= n_w) ? idx_q + IW'(1) : idx_q) > n_w) state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        // flag a non positive weighted sum, else pick the rule and start the first product
        if ($signed(wsum_q) <= 0) begin
          res_d = '0;
          bad_d = 1'b1;
          state_d = ST_OUT;
        end else begin
          fast_d  = $signed(rs_x10) <= $signed(t_x8);
          state_d = ST_MUL;
          step_d  = '0;
          mul_go  = 1'b1;
          mul_a   = '0;
          mul_b   = 32'd1;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          step_d = step_q + 2'd1;
          mul_go = 1'b1;
          case (step_q)
            2'd0: begin
              mul_a = {64'd0, span};
              mul_b = fast_q ? 32'(wwd_pkg::FastMult) : {16'd0, target_q};
              if (fast_q) step_d = 2'd3;
            end
            2'd1: mul_b = 32'({1'b0, n_w} + 1'b1);
            2'd2: mul_b = 32'(wwd_pkg::SlowMult);
            default: begin
              mul_go = 1'b0;
              div_req.go = 1'b1;
              if (fast_q) div_req.den = 64'(wwd_pkg::FastDiv);
              state_d = ST_DIV;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          res_d = div_rsp.quo;
          bad_d = 1'b0;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // result shown, set cleared
        idx_d = '0; prior_d = '0; wsum_d = '0; rsum_d = '0;
        first_d = '0; second_d = '0; newest_d = '0;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q <= '0; prior_q <= '0; wsum_q <= '0; rsum_q <= '0;
      first_q <= '0; second_q <= '0; newest_q <= '0;
      step_q <= '0; fast_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d; prior_q <= prior_d; wsum_q <= wsum_d; rsum_q <= rsum_d;
      first_q <= first_d; second_q <= second_d; newest_q <= newest_d;
      step_q <= step_d; fast_q <= fast_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) rec_q <= item_i;
    res_q <= res_d;
    bad_q <= bad_d;
  end

  wwd_mul u_mul (
    .clk_i, .rst_ni, .go_i(mul_go), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .p_o(mul_p)
  );

  wwd_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  assign busy    = (state_q != ST_IDLE);
  assign valid_o = (state_q == ST_OUT);
  assign result_o.next_difficulty = res_q;
  assign result_o.bad_span        = bad_q;

  // a result never coincides with a new transaction being taken
  a_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy) else $error("result while idle");
  // set state is clear after every result
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> idx_q == '0) else $error("set not cleared");
  // a flagged result is zero
  a_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.bad_span) |-> result_o.next_difficulty == '0)
    else $error("flag with nonzero result");

endmodule
